// ===== rtl/hdcf_pkg.sv =====
// Shared types, constants and helper functions for the hex dump CRC-16 framer.
`default_nettype none

package hdcf_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_OFS = 8'h61 - 8'd10;

	// One accepted byte, classified: what goes before it and what follows it.
	typedef struct packed {
		logic        hdr;
		logic        nl;
		logic        last;
		logic [7:0]  data;
		logic [15:0] fin;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [3:0] {
		ST_M,
		ST_P,
		ST_CR0,
		ST_LF0,
		ST_HI,
		ST_LO,
		ST_CR1,
		ST_LF1,
		ST_C3,
		ST_C2,
		ST_C1,
		ST_C0,
		ST_CR2,
		ST_LF2
	} step_t;

	// Reflected CRC-16, LSB first.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = CH_ZERO + {4'b0000, n};
		end else begin
			r = CH_A_OFS + {4'b0000, n};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hdcf_in_if.sv =====
// Input channel: raw log byte with last-byte flag.
`default_nettype none

interface hdcf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, output data_byte, output final_byte, input ready);
	modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/hdcf_out_if.sv =====
// Output channel: one ASCII character per beat.
`default_nettype none

interface hdcf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       run_last;

	modport source(output valid, output text_char, output run_last, input ready);
	modport sink(input valid, input text_char, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hex_dump_crc16_framer_unit.sv =====
// Top level of the hex dump CRC-16 framer: front end, descriptor queue, character back end.
//
//  channel  | dir | beat payload                  | handshake
//  ---------+-----+-------------------------------+-------------
//  in_ch    | in  | data_byte[7:0], final_byte     | valid/ready
//  out_ch   | out | text_char[7:0], run_last       | valid/ready
//
// The back end emits one character per cycle unless out_ch stalls or the queue is empty;
// a byte is 2 characters, 4 at a line start, 2 more on a dump's first, 8 more on its last.
// The front end takes a byte in the cycle its descriptor fits into the 2-entry queue.
// A byte's first character reaches the output register by way of its queue entry.
// arst_n clears CRC, line position, queue and sequencer; no clearing pass is needed.
// A stalled out_ch holds the output register; the queue then fills and drops in_ch.ready.
`default_nettype none

module hex_dump_crc16_framer_unit #(
	parameter int BYTES_PER_LINE = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	hdcf_in_if.sink     in_ch,
	hdcf_out_if.source  out_ch
);

	hdcf_pkg::desc_t  push_desc;
	hdcf_pkg::desc_t  head_desc;
	hdcf_pkg::qstat_t qstat;
	logic             push;
	logic             pop;

	hdcf_front #(
		.BYTES_PER_LINE(BYTES_PER_LINE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.qstat  (qstat),
		.push   (push),
		.desc   (push_desc)
	);

	hdcf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.rdata  (head_desc),
		.qstat  (qstat)
	);

	hdcf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_desc),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/hdcf_front.sv =====
// Front end: accepts bytes, tracks CRC, line position and dump start, builds descriptors.
`default_nettype none

module hdcf_front #(
	parameter int BYTES_PER_LINE = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	hdcf_in_if.sink            in_ch,
	input  hdcf_pkg::qstat_t   qstat,
	output logic               push,
	output hdcf_pkg::desc_t    desc
);

	localparam int LINE_W = (BYTES_PER_LINE > 2) ? $clog2(BYTES_PER_LINE) : 1;

	logic [15:0]       crc_q;
	logic [LINE_W-1:0] line_q;
	logic              started_q;
	logic [15:0]       crc_nxt;
	logic              line_wrap;

	assign in_ch.ready = !qstat.full;
	assign push        = in_ch.valid && in_ch.ready;

	assign crc_nxt   = hdcf_pkg::crc_update(crc_q, in_ch.data_byte);
	assign line_wrap = (line_q == LINE_W'(BYTES_PER_LINE - 1));

	always_comb begin
		desc.hdr  = !started_q;
		desc.nl   = (line_q == '0);
		desc.last = in_ch.final_byte;
		desc.data = in_ch.data_byte;
		desc.fin  = ~crc_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= hdcf_pkg::CRC_INIT;
			line_q    <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			if (in_ch.final_byte) begin
				crc_q     <= hdcf_pkg::CRC_INIT;
				line_q    <= '0;
				started_q <= 1'b0;
			end else begin
				crc_q     <= crc_nxt;
				line_q    <= line_wrap ? '0 : line_q + 1'b1;
				started_q <= 1'b1;
			end
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && in_ch.final_byte |=> crc_q == hdcf_pkg::CRC_INIT && line_q == '0 && !started_q)
		else $error("state not cleared after last byte");

	a_first_has_break: assert property (@(posedge clk) disable iff (!arst_n)
		push && desc.hdr |-> desc.nl)
		else $error("first byte of a dump without line break");

endmodule

`default_nettype wire

// ===== rtl/hdcf_fifo.sv =====
// Short descriptor queue between front and back end.
`default_nettype none

module hdcf_fifo (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  hdcf_pkg::desc_t   wdata,
	input  wire               pop,
	output hdcf_pkg::desc_t   rdata,
	output hdcf_pkg::qstat_t  qstat
);

	localparam int D  = hdcf_pkg::QDEPTH;
	localparam int PW = hdcf_pkg::QPTR_W;
	localparam int CW = hdcf_pkg::QCNT_W;

	hdcf_pkg::desc_t mem [D];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign qstat.full  = (cnt_q == CW'(D));
	assign qstat.empty = (cnt_q == '0);
	assign rdata       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/hdcf_back.sv =====
// Back end: walks the character sequence of the head descriptor into the output register.
`default_nettype none

module hdcf_back (
	input  wire               clk,
	input  wire               arst_n,
	input  hdcf_pkg::desc_t   head,
	input  hdcf_pkg::qstat_t  qstat,
	output logic              pop,
	hdcf_out_if.source        out_ch
);

	hdcf_pkg::step_t step_q;
	hdcf_pkg::step_t start_step;
	hdcf_pkg::step_t cur_step;
	hdcf_pkg::step_t nxt_step;
	logic            active_q;
	logic            out_valid_q;
	logic [7:0]      char_q;
	logic            last_q;
	logic            have;
	logic            advance;
	logic [7:0]      ch;
	logic            term;

	always_comb begin
		if (head.hdr) begin
			start_step = hdcf_pkg::ST_M;
		end else if (head.nl) begin
			start_step = hdcf_pkg::ST_CR0;
		end else begin
			start_step = hdcf_pkg::ST_HI;
		end
	end

	assign cur_step = active_q ? step_q : start_step;
	assign have     = active_q || !qstat.empty;
	assign advance  = have && (!out_valid_q || out_ch.ready);
	assign pop      = advance && term;

	// next state
	always_comb begin
		unique case (cur_step)
			hdcf_pkg::ST_M:   nxt_step = hdcf_pkg::ST_P;
			hdcf_pkg::ST_P:   nxt_step = head.nl ? hdcf_pkg::ST_CR0 : hdcf_pkg::ST_HI;
			hdcf_pkg::ST_CR0: nxt_step = hdcf_pkg::ST_LF0;
			hdcf_pkg::ST_LF0: nxt_step = hdcf_pkg::ST_HI;
			hdcf_pkg::ST_HI:  nxt_step = hdcf_pkg::ST_LO;
			hdcf_pkg::ST_LO:  nxt_step = hdcf_pkg::ST_CR1;
			hdcf_pkg::ST_CR1: nxt_step = hdcf_pkg::ST_LF1;
			hdcf_pkg::ST_LF1: nxt_step = hdcf_pkg::ST_C3;
			hdcf_pkg::ST_C3:  nxt_step = hdcf_pkg::ST_C2;
			hdcf_pkg::ST_C2:  nxt_step = hdcf_pkg::ST_C1;
			hdcf_pkg::ST_C1:  nxt_step = hdcf_pkg::ST_C0;
			hdcf_pkg::ST_C0:  nxt_step = hdcf_pkg::ST_CR2;
			hdcf_pkg::ST_CR2: nxt_step = hdcf_pkg::ST_LF2;
			hdcf_pkg::ST_LF2: nxt_step = hdcf_pkg::ST_M;
			default:          nxt_step = hdcf_pkg::ST_M;
		endcase
	end

	// character and end-of-item flag
	always_comb begin
		term = 1'b0;
		unique case (cur_step)
			hdcf_pkg::ST_M:   ch = hdcf_pkg::CH_M;
			hdcf_pkg::ST_P:   ch = hdcf_pkg::CH_P;
			hdcf_pkg::ST_CR0: ch = hdcf_pkg::CH_CR;
			hdcf_pkg::ST_LF0: ch = hdcf_pkg::CH_LF;
			hdcf_pkg::ST_HI:  ch = hdcf_pkg::hex_char(head.data[7:4]);
			hdcf_pkg::ST_LO: begin
				ch   = hdcf_pkg::hex_char(head.data[3:0]);
				term = !head.last;
			end
			hdcf_pkg::ST_CR1: ch = hdcf_pkg::CH_CR;
			hdcf_pkg::ST_LF1: ch = hdcf_pkg::CH_LF;
			hdcf_pkg::ST_C3:  ch = hdcf_pkg::hex_char(head.fin[15:12]);
			hdcf_pkg::ST_C2:  ch = hdcf_pkg::hex_char(head.fin[11:8]);
			hdcf_pkg::ST_C1:  ch = hdcf_pkg::hex_char(head.fin[7:4]);
			hdcf_pkg::ST_C0:  ch = hdcf_pkg::hex_char(head.fin[3:0]);
			hdcf_pkg::ST_CR2: ch = hdcf_pkg::CH_CR;
			hdcf_pkg::ST_LF2: begin
				ch   = hdcf_pkg::CH_LF;
				term = 1'b1;
			end
			default:          ch = hdcf_pkg::CH_LF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= hdcf_pkg::ST_M;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				active_q    <= !term;
				step_q      <= nxt_step;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_q <= ch;
			last_q <= term;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.text_char = char_q;
	assign out_ch.run_last  = last_q;

	a_active_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !qstat.empty)
		else $error("sequencer active with empty queue");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_ch.valid && out_ch.run_last)
		else $error("descriptor retired without last-character beat");

endmodule

`default_nettype wire

// ===== verif/hdcf_checker.sv =====
// Scoreboard for the hex dump framer: predicts the text stream from accepted bytes and compares.
`timescale 1ns / 1ps

module hdcf_checker #(
	parameter int BYTES_PER_LINE = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire [7:0]  in_data,
	input  wire        in_final,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire [7:0]  out_char,
	input  wire        out_last,
	output int         fail_count,
	output int         pending,
	output int         chars_checked,
	output int         dumps_closed
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	text_beat_t  expected_text[$];
	text_beat_t  want;
	logic [15:0] crc_acc;
	int          line_idx;
	logic        mp_sent;
	int          n_fail;
	int          n_chars;
	int          n_dumps;

	function automatic logic [7:0] digit_of(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = hdcf_pkg::CH_ZERO + 8'(n);
		end else begin
			r = hdcf_pkg::CH_A_OFS + 8'(n);
		end
		return r;
	endfunction

	// Reflected CRC-16, one bit per step, LSB of the data first.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[i]) begin
				c = (c >> 1) ^ 16'h8408;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	task automatic push_char(input logic [7:0] c);
		expected_text.push_back('{ch: c, last: 1'b0});
	endtask

	task automatic push_hex(input logic [7:0] b);
		push_char(digit_of(b[7:4]));
		push_char(digit_of(b[3:0]));
	endtask

	task automatic clear_dump();
		crc_acc  = 16'hFFFF;
		line_idx = 0;
		mp_sent  = 1'b0;
	endtask

	task automatic predict_text(input logic [7:0] b, input logic fin_flag);
		logic [15:0] crc_out;
		if (!mp_sent) begin
			push_char(hdcf_pkg::CH_M);
			push_char(hdcf_pkg::CH_P);
			mp_sent = 1'b1;
		end
		if (line_idx == 0) begin
			push_char(hdcf_pkg::CH_CR);
			push_char(hdcf_pkg::CH_LF);
		end
		push_hex(b);
		crc_acc  = crc_fold(crc_acc, b);
		line_idx = (line_idx + 1) % BYTES_PER_LINE;
		if (fin_flag) begin
			crc_out = ~crc_acc;
			push_char(hdcf_pkg::CH_CR);
			push_char(hdcf_pkg::CH_LF);
			push_hex(crc_out[15:8]);
			push_hex(crc_out[7:0]);
			push_char(hdcf_pkg::CH_CR);
			push_char(hdcf_pkg::CH_LF);
			clear_dump();
			n_dumps++;
		end
		expected_text[expected_text.size() - 1].last = 1'b1;
	endtask

	task automatic log_fault(input string msg);
		n_fail++;
		if (n_fail <= 10) begin
			$display("%s", msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_dump();
			expected_text.delete();
			n_fail  = 0;
			n_chars = 0;
			n_dumps = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					log_fault($sformatf("unexpected char %h last %b, nothing pending",
						out_char, out_last));
				end else begin
					want = expected_text.pop_front();
					if (out_char !== want.ch || out_last !== want.last) begin
						log_fault($sformatf("char %0d: expected %h last %b, got %h last %b",
							n_chars, want.ch, want.last, out_char, out_last));
					end
					n_chars++;
				end
			end
			// a byte never shows up on the output in the edge it was taken
			if (in_valid && in_ready) begin
				predict_text(in_data, in_final);
			end
		end
		fail_count    <= n_fail;
		pending       <= expected_text.size();
		chars_checked <= n_chars;
		dumps_closed  <= n_dumps;
	end

endmodule

// ===== verif/tb_top.sv =====
// Top of the hex dump framer testbench: clock, reset, byte stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int LINE_BYTES   = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_BYTES  = 77;

	localparam logic [7:0] EDGE_BYTES [17] = '{
		8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F,
		8'hFE, 8'h10, 8'h09, 8'h0A, 8'h39, 8'hC3, 8'h3C, 8'h96
	};

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_gen  = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   cycle_count = 0;
	int   bytes_sent  = 0;

	int   fail_count;
	int   pending;
	int   chars_checked;
	int   dumps_closed;

	hdcf_in_if  in_ch();
	hdcf_out_if out_ch();

	hex_dump_crc16_framer_unit #(
		.BYTES_PER_LINE(LINE_BYTES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	hdcf_checker #(
		.BYTES_PER_LINE(LINE_BYTES)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_data       (in_ch.data_byte),
		.in_final      (in_ch.final_byte),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_char      (out_ch.text_char),
		.out_last      (out_ch.run_last),
		.fail_count    (fail_count),
		.pending       (pending),
		.chars_checked (chars_checked),
		.dumps_closed  (dumps_closed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d chars pending", cycle_count, pending);
			$display("hex_dump_crc16_framer_unit regression: fail");
			$finish;
		end
	end

	// Output side: random stalls, plus a long hold-off whenever hold_gen moves.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_gen != hold_seen) begin
			hold_seen    <= hold_gen;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Returns right after the edge where the beat was taken.
	task automatic send_byte(input logic [7:0] b, input logic fin_flag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.final_byte <= fin_flag;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_dump(input int len);
		for (int k = 0; k < len; k++) begin
			send_byte(8'($urandom_range(255)), k == len - 1);
		end
	endtask

	initial begin
		int phase_sent;
		int len;

		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.data_byte  = 8'h00;
		in_ch.final_byte = 1'b0;
		send_idle_pct    = 25;
		recv_idle_pct    = 62;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte dumps at both extremes, then a dump that wraps past one line
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		for (int k = 0; k < 17; k++) begin
			send_byte(EDGE_BYTES[k], k == 16);
		end

		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct <= 62;
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct <= 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
					hold_gen <= hold_gen + 1;
				end
			endcase
			phase_sent = 0;
			while (phase_sent < PHASE_BYTES) begin
				if ($urandom_range(4) == 0) begin
					len = $urandom_range(48, 17);
				end else begin
					len = $urandom_range(20, 1);
				end
				send_dump(len);
				phase_sent += len;
			end
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d dumps, checked %0d characters", bytes_sent,
			dumps_closed, chars_checked);
		$display("stall mixes 25/62, 62/25 and none, plus a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("hex_dump_crc16_framer_unit regression: pass");
		end else begin
			$display("hex_dump_crc16_framer_unit regression: fail");
		end
		$finish;
	end

endmodule
